### rtl/core/rpd_pkg.sv
// Shared types and constants for the region presence detector.
// Used by the controller, the datapath, the divider, the top level and the checker.
package rpd_pkg;

  localparam int PIX_W    = 8;
  localparam int START_W  = 10;
  localparam int END_W    = 11;
  localparam int SUM_W    = 26;
  localparam int CNT_W    = 17;
  localparam int CSUM_W   = 16;
  localparam int RUN_W    = 8;
  localparam int CFG_W    = 11;
  localparam int IDX_W    = 3;
  localparam int QSTEP_W  = $clog2(PIX_W);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic ACT_RECAL = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_X_START    = 3'd0,
    REG_Y_START    = 3'd1,
    REG_X_END      = 3'd2,
    REG_Y_END      = 3'd3,
    REG_THRESHOLD  = 3'd4,
    REG_ON_FRAMES  = 3'd5,
    REG_OFF_FRAMES = 3'd6,
    REG_CAL_FRAMES = 3'd7
  } reg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SAMPLE = 9'b000000010,
    S_SDIV   = 9'b000000100,
    S_SWAIT  = 9'b000001000,
    S_CAL    = 9'b000010000,
    S_CDIV   = 9'b000100000,
    S_CWAIT  = 9'b001000000,
    S_DECIDE = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic sample;
    logic sdiv_start;
    logic frame_end;
    logic cdiv_start;
    logic cal_finish;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic frame_last;
    logic div_busy;
    logic calibrated;
    logic cal_reached;
    logic out_free;
  } status_t;

endpackage

### rtl/core/roi_presence_detector.sv
// Top level of the region presence detector: controller plus datapath, depends on rpd_pkg.
// A pixel item passes through the load and sample states; a recalibrate item clears the state
// from idle. The item that closes a frame also runs the shared divider, which forms the frame
// mean and, when it completes calibration, the baseline, one quotient bit per cycle over eight
// steps. A result may wait in the output register while the next item is accepted; a result
// that cannot be handed over holds the block once the following frame end is reached.
module roi_presence_detector #(
  parameter int COORD_BITS  = 10,
  parameter int SAMPLE_STEP = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rpd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rpd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [rpd_pkg::PIX_W-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0]       pixel_x,
  input  logic [COORD_BITS-1:0]       pixel_y,
  input  logic                        frame_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        present,
  output logic                        calibrated,
  output logic [rpd_pkg::PIX_W-1:0]   score,
  output logic [rpd_pkg::PIX_W-1:0]   difference,
  output logic [rpd_pkg::PIX_W-1:0]   baseline
);
  import rpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  rpd_datapath #(
    .COORD_BITS  (COORD_BITS),
    .SAMPLE_STEP (SAMPLE_STEP)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_value (pixel_value),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .frame_last  (frame_last),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .present     (present),
    .calibrated  (calibrated),
    .score       (score),
    .difference  (difference),
    .baseline    (baseline)
  );

endmodule

### rtl/core/rpd_div.sv
// Iterative divider giving an eight-bit quotient, one quotient bit per cycle.
// Depends on rpd_pkg; the dividend must be below 256 times the divisor.
module rpd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rpd_pkg::SUM_W-1:0]  dividend,
  input  logic [rpd_pkg::CNT_W-1:0]  divisor,
  output logic                       busy,
  output logic [rpd_pkg::PIX_W-1:0]  quotient
);
  import rpd_pkg::*;

  logic [SUM_W-1:0]   rem;
  logic [CNT_W-1:0]   dsr;
  logic [QSTEP_W-1:0] step;
  logic [SUM_W-1:0]   trial;
  logic               fits;

  assign trial = SUM_W'(dsr) << step;
  assign fits  = (rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && (step == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= divisor;
      step     <= QSTEP_W'(PIX_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem            <= rem - trial;
        quotient[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

endmodule

### rtl/core/rpd_ctrl.sv
// Controller state machine that sequences sampling, division and debouncing.
// Depends on rpd_pkg for the state, command and status types.
module rpd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             action,
  output logic             in_stall,
  output rpd_pkg::cmd_t    cmd,
  input  rpd_pkg::status_t status
);
  import rpd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_RECAL) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_SAMPLE;
          end
        end
      end
      S_SAMPLE: begin
        cmd.sample = 1'b1;
        state_next = status.frame_last ? S_SDIV : S_IDLE;
      end
      S_SDIV: begin
        cmd.sdiv_start = 1'b1;
        state_next     = S_SWAIT;
      end
      S_SWAIT: begin
        if (!status.div_busy) begin
          state_next = S_CAL;
        end
      end
      S_CAL: begin
        cmd.frame_end = 1'b1;
        state_next = (!status.calibrated && status.cal_reached) ? S_CDIV : S_DECIDE;
      end
      S_CDIV: begin
        cmd.cdiv_start = 1'b1;
        state_next     = S_CWAIT;
      end
      S_CWAIT: begin
        if (!status.div_busy) begin
          cmd.cal_finish = 1'b1;
          state_next     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/rpd_datapath.sv
// Datapath: configuration registers, region sampling, calibration, debounce and result register.
// Depends on rpd_pkg and instantiates rpd_div.
module rpd_datapath #(
  parameter int COORD_BITS  = 10,
  parameter int SAMPLE_STEP = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rpd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [rpd_pkg::CFG_W-1:0]   cfg_data,
  input  logic [rpd_pkg::PIX_W-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0]       pixel_x,
  input  logic [COORD_BITS-1:0]       pixel_y,
  input  logic                        frame_last,
  input  rpd_pkg::cmd_t               cmd,
  output rpd_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        present,
  output logic                        calibrated,
  output logic [rpd_pkg::PIX_W-1:0]   score,
  output logic [rpd_pkg::PIX_W-1:0]   difference,
  output logic [rpd_pkg::PIX_W-1:0]   baseline
);
  import rpd_pkg::*;

  localparam int DW = (COORD_BITS > START_W) ? COORD_BITS : START_W;
  localparam int CW = (COORD_BITS > END_W) ? COORD_BITS : END_W;
  localparam int GS = DW + 4;
  localparam logic [GS:0] GM = (GS+1)'((2**GS + SAMPLE_STEP - 1) / SAMPLE_STEP);
  localparam int PW = DW + GS + 1;

  logic [START_W-1:0] x_start, y_start;
  logic [END_W-1:0]   x_end, y_end;
  logic [PIX_W-1:0]   threshold;
  logic [RUN_W-1:0]   on_need, off_need;
  logic [RUN_W-1:0]   cal_frames;

  logic [PIX_W-1:0] pix_r;
  logic [DW-1:0]    dx_r, dy_r;
  logic             x_in, y_in, last_r;

  logic [SUM_W-1:0]  region_sum;
  logic [CNT_W-1:0]  region_count;
  logic [CSUM_W-1:0] calib_sum;
  logic [RUN_W-1:0]  calib_count;
  logic [PIX_W-1:0]  baseline_value;
  logic              calibrated_flag;
  logic              present_flag;
  logic [RUN_W-1:0]  on_run, off_run;
  logic [PIX_W-1:0]  last_difference;
  logic [PIX_W-1:0]  score_r;
  logic              raw;

  logic [PW-1:0]     prod_x, prod_y;
  logic              grid_x, grid_y, take;
  logic              div_start, div_busy;
  logic [SUM_W-1:0]  div_dividend;
  logic [CNT_W-1:0]  div_divisor;
  logic [PIX_W-1:0]  quotient;
  logic [PIX_W-1:0]  score_w, diff_w;
  logic [RUN_W-1:0]  calib_count_inc;
  logic [RUN_W:0]    on_inc, off_inc;
  logic [RUN_W-1:0]  on_n, off_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start    <= '0;
      y_start    <= '0;
      x_end      <= END_W'(160);
      y_end      <= END_W'(120);
      threshold  <= PIX_W'(20);
      on_need    <= RUN_W'(3);
      off_need   <= RUN_W'(3);
      cal_frames <= RUN_W'(10);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_START:    x_start    <= cfg_data[START_W-1:0];
        REG_Y_START:    y_start    <= cfg_data[START_W-1:0];
        REG_X_END:      x_end      <= cfg_data[END_W-1:0];
        REG_Y_END:      y_end      <= cfg_data[END_W-1:0];
        REG_THRESHOLD:  threshold  <= cfg_data[PIX_W-1:0];
        REG_ON_FRAMES:  on_need    <= cfg_data[RUN_W-1:0];
        REG_OFF_FRAMES: off_need   <= cfg_data[RUN_W-1:0];
        REG_CAL_FRAMES: cal_frames <= cfg_data[RUN_W-1:0];
      endcase
    end
  end

  // Range test and corner offsets are captured with the item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r  <= pixel_value;
      dx_r   <= DW'(pixel_x) - DW'(x_start);
      dy_r   <= DW'(pixel_y) - DW'(y_start);
      x_in   <= (CW'(pixel_x) >= CW'(x_start)) && (CW'(pixel_x) < CW'(x_end));
      y_in   <= (CW'(pixel_y) >= CW'(y_start)) && (CW'(pixel_y) < CW'(y_end));
      last_r <= frame_last;
    end
  end

  // An offset is a multiple of the step exactly when the fraction bits of
  // offset times the rounded-up reciprocal stay below that reciprocal.
  assign prod_x = PW'(dx_r) * PW'(GM);
  assign prod_y = PW'(dy_r) * PW'(GM);
  assign grid_x = x_in && ({1'b0, prod_x[GS-1:0]} < GM);
  assign grid_y = y_in && ({1'b0, prod_y[GS-1:0]} < GM);
  assign take   = grid_x && grid_y && (region_count != COUNT_MAX);

  assign div_start    = cmd.sdiv_start || cmd.cdiv_start;
  assign div_dividend = cmd.cdiv_start ? SUM_W'(calib_sum) : region_sum;
  assign div_divisor  = cmd.cdiv_start ? CNT_W'(calib_count) : region_count;

  rpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign score_w = (region_count == '0) ? '0 : quotient;
  assign diff_w  = (score_w >= baseline_value) ? (score_w - baseline_value)
                                               : (baseline_value - score_w);
  assign calib_count_inc = calib_count + 1'b1;

  assign on_inc  = {1'b0, on_run} + 1'b1;
  assign off_inc = {1'b0, off_run} + 1'b1;
  assign on_n    = (on_inc > {1'b0, on_need}) ? on_need : on_inc[RUN_W-1:0];
  assign off_n   = (off_inc > {1'b0, off_need}) ? off_need : off_inc[RUN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      region_sum      <= '0;
      region_count    <= '0;
      calib_sum       <= '0;
      calib_count     <= '0;
      baseline_value  <= '0;
      calibrated_flag <= 1'b0;
      present_flag    <= 1'b0;
      on_run          <= '0;
      off_run         <= '0;
      last_difference <= '0;
      raw             <= 1'b0;
    end else begin
      if (cmd.sample && take) begin
        region_sum   <= region_sum + SUM_W'(pix_r);
        region_count <= region_count + 1'b1;
      end
      if (cmd.frame_end) begin
        region_sum   <= '0;
        region_count <= '0;
        if (!calibrated_flag) begin
          calib_sum       <= calib_sum + CSUM_W'(score_w);
          calib_count     <= calib_count_inc;
          last_difference <= '0;
          raw             <= 1'b0;
        end else begin
          last_difference <= diff_w;
          raw             <= (diff_w >= threshold);
        end
      end
      if (cmd.cal_finish) begin
        baseline_value  <= quotient;
        calibrated_flag <= 1'b1;
      end
      if (cmd.decide) begin
        if (raw) begin
          on_run  <= on_n;
          off_run <= '0;
          if (on_n >= on_need) begin
            present_flag <= 1'b1;
          end
        end else begin
          off_run <= off_n;
          on_run  <= '0;
          if (off_n >= off_need) begin
            present_flag <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_end) begin
      score_r <= score_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      present    <= present_flag;
      calibrated <= calibrated_flag;
      score      <= score_r;
      difference <= last_difference;
      baseline   <= baseline_value;
    end
  end

  assign status.frame_last  = last_r;
  assign status.div_busy    = div_busy;
  assign status.calibrated  = calibrated_flag;
  assign status.cal_reached = (calib_count_inc >= cal_frames);
  assign status.out_free    = !out_valid || !out_stall;

endmodule

### rtl/core/rpd_checker.sv
// Port-level checks for the region presence detector and the bind that attaches them.
// Depends on rpd_pkg and on the ports of roi_presence_detector.
module rpd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      present,
  input logic                      calibrated,
  input logic [rpd_pkg::PIX_W-1:0] score,
  input logic [rpd_pkg::PIX_W-1:0] difference,
  input logic [rpd_pkg::PIX_W-1:0] baseline
);
  import rpd_pkg::*;

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(score) && $stable(difference) &&
      $stable(baseline) && $stable(present) && $stable(calibrated))
    else $error("Stalled result changed.");

  a_uncal_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !calibrated |-> (difference == '0) && (baseline == '0))
    else $error("Difference or baseline nonzero before calibration.");

  a_present_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid && present |-> calibrated)
    else $error("Presence reported without a baseline.");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared while the block was idle.");

endmodule

bind roi_presence_detector rpd_checker u_rpd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .present    (present),
  .calibrated (calibrated),
  .score      (score),
  .difference (difference),
  .baseline   (baseline)
);

### verif/roi_presence_detector_tb.sv
// Self-checking testbench for roi_presence_detector: drives pixel and recalibrate items,
// predicts each end-of-frame report and compares it field by field with the block's output.
// Depends on rpd_pkg and the roi_presence_detector RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpd_pkg::*;

  localparam int COORD_W = 10;
  localparam int STEP = 3;
  localparam int COORD_TOP = (1 << COORD_W) - 1;
  localparam logic ACT_PIXEL = 1'b0;

  typedef struct {
    logic action;
    logic [PIX_W-1:0] value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic last;
  } pixel_item_t;

  typedef struct {
    logic present;
    logic calibrated;
    logic [PIX_W-1:0] score;
    logic [PIX_W-1:0] difference;
    logic [PIX_W-1:0] baseline;
  } frame_report_t;

  class presence_tracker;
    logic [START_W-1:0] x_lo, y_lo;
    logic [END_W-1:0] x_hi, y_hi;
    logic [7:0] thr, on_need, off_need, cal_need;
    logic [SUM_W-1:0] region_sum;
    logic [CNT_W-1:0] region_count;
    logic [CSUM_W-1:0] calib_sum;
    logic [7:0] calib_count, base_level, last_diff;
    logic cal_done, present_now;
    logic [RUN_W-1:0] on_run, off_run;
    frame_report_t pending_reports[$];
    int errors, items_seen, reports_seen;

    function void clear_state();
      region_sum = '0;
      region_count = '0;
      calib_sum = '0;
      calib_count = '0;
      base_level = '0;
      last_diff = '0;
      cal_done = 1'b0;
      present_now = 1'b0;
      on_run = '0;
      off_run = '0;
    endfunction

    function void power_on();
      x_lo = 0;
      y_lo = 0;
      x_hi = 160;
      y_hi = 120;
      thr = 20;
      on_need = 3;
      off_need = 3;
      cal_need = 10;
      errors = 0;
      items_seen = 0;
      reports_seen = 0;
      clear_state();
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_X_START: x_lo = data[START_W-1:0];
        REG_Y_START: y_lo = data[START_W-1:0];
        REG_X_END: x_hi = data[END_W-1:0];
        REG_Y_END: y_hi = data[END_W-1:0];
        REG_THRESHOLD: thr = data[7:0];
        REG_ON_FRAMES: on_need = data[7:0];
        REG_OFF_FRAMES: off_need = data[7:0];
        REG_CAL_FRAMES: cal_need = data[7:0];
        default: ;
      endcase
    endfunction

    function bit on_grid(int p, int lo, int hi);
      if (p < lo || p >= hi) return 1'b0;
      return ((p - lo) % STEP) == 0;
    endfunction

    function void debounce(bit raw);
      int n;
      if (raw) begin
        n = int'(on_run) + 1;
        if (n > on_need) n = on_need;
        on_run = n[RUN_W-1:0];
        off_run = '0;
        if (on_run >= on_need) present_now = 1'b1;
      end else begin
        n = int'(off_run) + 1;
        if (n > off_need) n = off_need;
        off_run = n[RUN_W-1:0];
        on_run = '0;
        if (off_run >= off_need) present_now = 1'b0;
      end
    endfunction

    function void take_item(pixel_item_t it);
      frame_report_t rep;
      logic [PIX_W-1:0] mean;
      int q, d;
      bit raw;
      items_seen++;
      if (it.action == ACT_RECAL) begin
        clear_state();
        return;
      end
      if (on_grid(it.x, x_lo, x_hi) && on_grid(it.y, y_lo, y_hi) &&
          region_count != COUNT_MAX) begin
        region_sum += it.value;
        region_count += 1;
      end
      if (!it.last) return;
      q = (region_count == 0) ? 0 : region_sum / region_count;
      mean = q[PIX_W-1:0];
      region_sum = '0;
      region_count = '0;
      if (!cal_done) begin
        calib_sum += mean;
        calib_count += 1;
        last_diff = '0;
        if (calib_count >= cal_need) begin
          q = calib_sum / calib_count;
          base_level = q[7:0];
          cal_done = 1'b1;
        end
        raw = 1'b0;
      end else begin
        d = (mean >= base_level) ? int'(mean) - int'(base_level)
                                 : int'(base_level) - int'(mean);
        last_diff = d[7:0];
        raw = last_diff >= thr;
      end
      debounce(raw);
      rep.present = present_now;
      rep.calibrated = cal_done;
      rep.score = mean;
      rep.difference = last_diff;
      rep.baseline = cal_done ? base_level : '0;
      pending_reports.push_back(rep);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t want;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("frame report arrived with no frame end outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare("present", want.present, got.present);
      compare("calibrated", want.calibrated, got.calibrated);
      compare("score", want.score, got.score);
      compare("difference", want.difference, got.difference);
      compare("baseline", want.baseline, got.baseline);
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic action;
  logic [PIX_W-1:0] pixel_value;
  logic [COORD_W-1:0] pixel_x, pixel_y;
  logic frame_last;
  logic out_valid, out_stall;
  logic present, calibrated;
  logic [PIX_W-1:0] score, difference, baseline;

  int idle_pct = 28;
  int stall_pct = 28;
  int hold_left = 0;
  int settings_used = 0;
  presence_tracker tracker = new;

  roi_presence_detector #(
    .COORD_BITS(COORD_W),
    .SAMPLE_STEP(STEP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .pixel_value(pixel_value),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .frame_last(frame_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .present(present),
    .calibrated(calibrated),
    .score(score),
    .difference(difference),
    .baseline(baseline)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("roi_presence_detector regression: fail");
    $finish;
  end

  initial begin
    frame_report_t got;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        got.present = present;
        got.calibrated = calibrated;
        got.score = score;
        got.difference = difference;
        got.baseline = baseline;
        tracker.check_report(got);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(pixel_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= it.action;
    pixel_value <= it.value;
    pixel_x <= it.x;
    pixel_y <= it.y;
    frame_last <= it.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(it);
  endtask

  task automatic send_px(logic act, int v, int x, int y, logic last);
    pixel_item_t it;
    it.action = act;
    it.value = PIX_W'(v);
    it.x = COORD_W'(x);
    it.y = COORD_W'(y);
    it.last = last;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic set_cfg(int xs, int ys, int xe, int ye, int th, int on, int off, int cal);
    write_reg(REG_X_START, CFG_W'(xs));
    write_reg(REG_Y_START, CFG_W'(ys));
    write_reg(REG_X_END, CFG_W'(xe));
    write_reg(REG_Y_END, CFG_W'(ye));
    write_reg(REG_THRESHOLD, CFG_W'(th));
    write_reg(REG_ON_FRAMES, CFG_W'(on));
    write_reg(REG_OFF_FRAMES, CFG_W'(off));
    write_reg(REG_CAL_FRAMES, CFG_W'(cal));
    cfg_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic int pick_end(int start);
    case ($urandom_range(9))
      0: return $urandom_range(start, 0);
      1: return 1024;
      2: return $urandom_range(2047, 1024);
      default: return start + $urandom_range(18, 1);
    endcase
  endfunction

  function automatic int pick_count(bit allow_max);
    case ($urandom_range(5))
      0: return 0;
      1: return 1;
      2: return allow_max ? 255 : 2;
      default: return $urandom_range(4, 2);
    endcase
  endfunction

  // Upper bits of the start, threshold, run-length and calibration writes carry junk that the register must drop.
  task automatic random_config();
    int xs, ys, xe, ye, th;
    xs = ($urandom_range(9) == 0) ? $urandom_range(1023, 1000) : $urandom_range(40);
    ys = ($urandom_range(9) == 0) ? $urandom_range(1023, 1000) : $urandom_range(40);
    xe = pick_end(xs);
    ye = pick_end(ys);
    case ($urandom_range(4))
      0: th = 0;
      1: th = 255;
      default: th = $urandom_range(50, 1);
    endcase
    set_cfg(xs + 1024 * $urandom_range(1), ys + 1024 * $urandom_range(1), xe, ye,
            th + 256 * $urandom_range(7), pick_count(1) + 256 * $urandom_range(7),
            pick_count(1) + 256 * $urandom_range(7), pick_count(0) + 256 * $urandom_range(7));
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(int lo, int hi);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = (hi > lo) ? lo + STEP * $urandom_range((hi - lo - 1) / STEP)
                                      : lo + int'($urandom_range(6)) - 3;
      6, 7: v = ($urandom_range(1) ? lo : hi) + int'($urandom_range(6)) - 3;
      default: v = $urandom_range(COORD_TOP);
    endcase
    if (v < 0) v = 0;
    if (v > COORD_TOP) v = COORD_TOP;
    return v[COORD_W-1:0];
  endfunction

  task automatic send_frame(int npix, int level, int spread);
    pixel_item_t it;
    int v;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(99) < 3) begin
        it.action = ACT_RECAL;
        it.value = PIX_W'($urandom);
        it.x = COORD_W'($urandom);
        it.y = COORD_W'($urandom);
        it.last = 1'($urandom_range(1));
        send_item(it);
      end
      v = level + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      it.action = ACT_PIXEL;
      it.value = PIX_W'(v);
      it.x = pick_coord(tracker.x_lo, tracker.x_hi);
      it.y = pick_coord(tracker.y_lo, tracker.y_hi);
      it.last = (i == npix - 1);
      send_item(it);
    end
  endtask

  // The scene stays near one brightness and now and then moves away from it for a while,
  // so that runs of present and absent frames build up.
  task automatic run_phase(int budget, int frame_max);
    int sent, npix, level, home, spread;
    bit away;
    home = $urandom_range(255);
    away = 1'b0;
    sent = 0;
    if ($urandom_range(9) < 6) send_px(ACT_RECAL, $urandom, $urandom, $urandom, 1'b1);
    while (sent < budget) begin
      if ($urandom_range(3) == 0) away = !away;
      npix = $urandom_range(frame_max, 1);
      if (away) begin
        level = home + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(120, 20));
      end else begin
        level = home + int'($urandom_range(6)) - 3;
      end
      spread = ($urandom_range(9) == 0) ? 255 : $urandom_range(8);
      send_frame(npix, level, spread);
      sent += npix;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_X_START;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= ACT_PIXEL;
    pixel_value <= '0;
    pixel_x <= '0;
    pixel_y <= '0;
    frame_last <= 1'b0;
    tracker.power_on();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-frame calibration, samples on and off the grid, empty sample, zero threshold.
    set_cfg(0, 0, 7, 7, 0, 1, 1, 1);
    send_px(ACT_PIXEL, 255, 0, 0, 1'b0);
    send_px(ACT_PIXEL, 0, 3, 3, 1'b0);
    send_px(ACT_PIXEL, 255, 6, 6, 1'b0);
    send_px(ACT_PIXEL, 99, 7, 0, 1'b0);
    send_px(ACT_PIXEL, 99, 1, 0, 1'b0);
    send_px(ACT_PIXEL, 99, COORD_TOP, COORD_TOP, 1'b0);
    send_px(ACT_PIXEL, 128, 0, 3, 1'b1);
    send_px(ACT_PIXEL, 77, 2, 2, 1'b1);
    send_px(ACT_PIXEL, 159, 0, 0, 1'b1);
    send_px(ACT_RECAL, 255, COORD_TOP, COORD_TOP, 1'b1);
    send_px(ACT_PIXEL, 10, 0, 0, 1'b0);
    send_px(ACT_RECAL, 0, 0, 0, 1'b0);
    send_px(ACT_PIXEL, 20, 3, 0, 1'b1);
    wait_idle();

    // Region in the far corner, maximum threshold and run lengths, zero calibration frames.
    set_cfg(1023, 1023, 1024, 1024, 255, 255, 255, 0);
    send_px(ACT_PIXEL, 255, 1023, 1023, 1'b1);
    send_px(ACT_PIXEL, 0, 1023, 1023, 1'b1);
    send_px(ACT_PIXEL, 255, 1022, 1023, 1'b1);
    wait_idle();

    // End below start on one axis and equal to start on the other.
    set_cfg(1024 + 5, 0, 2, 0, 1, 2, 2, 2);
    send_px(ACT_PIXEL, 200, 5, 0, 1'b1);
    send_px(ACT_PIXEL, 200, 6, 0, 1'b1);
    send_px(ACT_PIXEL, 200, 0, 0, 1'b1);
    wait_idle();

    set_cfg(0, 0, 160, 120, 20, 3, 3, 10);
    run_phase(30, 4);
    wait_idle();

    // Longest calibration, single-pixel frames with bright values to load the sum.
    set_cfg(0, 0, 3, 3, 5, 0, 0, 255);
    send_px(ACT_RECAL, 0, 0, 0, 1'b0);
    repeat (258) send_px(ACT_PIXEL, $urandom_range(255, 180), 0, 0, 1'b1);
    run_phase(20, 3);
    wait_idle();

    repeat (3) begin
      random_config();
      run_phase(25, 8);
      wait_idle();
    end

    // Receiver holds off while short frames keep coming, so the block backs up.
    random_config();
    hold_left = 400;
    run_phase(40, 2);
    wait_idle();

    idle_pct = 0;
    stall_pct = 0;
    random_config();
    run_phase(30, 8);
    wait_idle();
    idle_pct = 28;
    stall_pct = 28;

    repeat (2) begin
      random_config();
      run_phase(25, 8);
      wait_idle();
    end

    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.pending_reports.size() != 0) begin
      $error("%0d frame reports never arrived", tracker.pending_reports.size());
      tracker.errors++;
    end
    $display("Ran %0d items through %0d register settings, a full-length calibration",
             tracker.items_seen, settings_used);
    $display("and a long output hold; checked %0d frame reports, %0d mismatches.",
             tracker.reports_seen, tracker.errors);
    if (tracker.errors == 0) begin
      $display("roi_presence_detector regression: pass");
    end else begin
      $display("roi_presence_detector regression: fail");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/rpd_pkg.sv
rtl/core/rpd_div.sv
rtl/core/rpd_ctrl.sv
rtl/core/rpd_datapath.sv
rtl/core/roi_presence_detector.sv
rtl/core/rpd_checker.sv
verif/roi_presence_detector_tb.sv
